[sv/kpl_pkg.sv]
// kpl_pkg: shared constants, codes and types of the keypad password lock
// used by kpl_core and keypad_password_lock; no dependencies
package kpl_pkg;

	localparam int PASSWORD_LENGTH = 5;
	localparam int CNT_W = $clog2(PASSWORD_LENGTH + 1);
	localparam int IDX_W = (PASSWORD_LENGTH > 1) ? $clog2(PASSWORD_LENGTH) : 1;
	localparam int KEY_W = 8;
	localparam int OUTCOME_W = 3;

	// key codes (ascii)
	localparam logic [KEY_W-1:0] KEY_STAR  = 8'h2A;
	localparam logic [KEY_W-1:0] KEY_HASH  = 8'h23;
	localparam logic [KEY_W-1:0] KEY_PLUS  = 8'h2B;
	localparam logic [KEY_W-1:0] KEY_MINUS = 8'h2D;
	localparam logic [KEY_W-1:0] KEY_THREE = 8'h33;
	localparam logic [KEY_W-1:0] KEY_ONE   = 8'h31;

	// mode codes
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_ENTRY   = 3'd1;
	localparam logic [2:0] MODE_MENU    = 3'd2;
	localparam logic [2:0] MODE_OLD     = 3'd3;
	localparam logic [2:0] MODE_NEW     = 3'd4;
	localparam logic [2:0] MODE_CONFIRM = 3'd5;

	// outcome codes
	localparam logic [OUTCOME_W-1:0] OUT_VALID     = 3'd0;
	localparam logic [OUTCOME_W-1:0] OUT_WRONG     = 3'd1;
	localparam logic [OUTCOME_W-1:0] OUT_WRONG_OLD = 3'd2;
	localparam logic [OUTCOME_W-1:0] OUT_MISMATCH  = 3'd3;
	localparam logic [OUTCOME_W-1:0] OUT_UPDATED   = 3'd4;

	typedef logic [PASSWORD_LENGTH-1:0][KEY_W-1:0] pw_t;

	typedef struct packed {
		logic                 valid;
		logic [OUTCOME_W-1:0] outcome;
	} kpl_result_t;

	// password after reset: "12345", continued upward
	function automatic pw_t reset_password();
		pw_t pw;
		for (int i = 0; i < PASSWORD_LENGTH; i++) begin
			pw[i] = KEY_W'(KEY_ONE + KEY_W'(i));
		end
		return pw;
	endfunction

endpackage

[sv/kpl_core.sv]
// kpl_core: mode machine, key buffers, stored password and compares
// processes one registered key per fire; depends on kpl_pkg
module kpl_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  logic [kpl_pkg::KEY_W-1:0] key,
	output kpl_pkg::kpl_result_t      res
);
	import kpl_pkg::*;

	logic [2:0]       mode_q, mode_d;
	logic [CNT_W-1:0] count_q, count_d;
	pw_t              stored_q;
	pw_t              entry_q;
	pw_t              new_q;
	pw_t              entry_with_key;
	logic             wr_entry, wr_new, commit;
	logic             match_stored_buf, match_stored_now, match_new_now;
	logic             last_key;
	logic [IDX_W-1:0] idx;

	assign idx = count_q[IDX_W-1:0];
	assign last_key = (count_q == CNT_W'(PASSWORD_LENGTH - 1));

	// entry buffer as it stands once the current key is written
	always_comb begin
		entry_with_key = entry_q;
		entry_with_key[idx] = key;
	end

	// character compares, one per position
	always_comb begin
		match_stored_buf = 1'b1;
		match_stored_now = 1'b1;
		match_new_now    = 1'b1;
		for (int i = 0; i < PASSWORD_LENGTH; i++) begin
			if (entry_q[i] != stored_q[i]) match_stored_buf = 1'b0;
			if (entry_with_key[i] != stored_q[i]) match_stored_now = 1'b0;
			if (entry_with_key[i] != new_q[i]) match_new_now = 1'b0;
		end
	end

	// next mode, count and result
	always_comb begin
		mode_d   = mode_q;
		count_d  = count_q;
		wr_entry = 1'b0;
		wr_new   = 1'b0;
		commit   = 1'b0;
		res      = '0;
		unique case (mode_q)
			MODE_ENTRY: begin
				if (key == KEY_STAR) begin
					if (count_q != '0) count_d = count_q - CNT_W'(1);
				end else if (key == KEY_HASH) begin
					mode_d      = MODE_IDLE;
					count_d     = '0;
					res.valid   = 1'b1;
					res.outcome = ((count_q == CNT_W'(PASSWORD_LENGTH)) && match_stored_buf)
						? OUT_VALID : OUT_WRONG;
				end else if (count_q < CNT_W'(PASSWORD_LENGTH)) begin
					wr_entry = 1'b1;
					count_d  = count_q + CNT_W'(1);
				end
			end
			MODE_MENU: begin
				count_d = '0;
				mode_d  = (key == KEY_THREE) ? MODE_OLD : MODE_IDLE;
			end
			MODE_OLD: begin
				wr_entry = 1'b1;
				if (last_key) begin
					count_d = '0;
					if (!match_stored_now) begin
						mode_d      = MODE_IDLE;
						res.valid   = 1'b1;
						res.outcome = OUT_WRONG_OLD;
					end else begin
						mode_d = MODE_NEW;
					end
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			MODE_NEW: begin
				wr_new = 1'b1;
				if (last_key) begin
					count_d = '0;
					mode_d  = MODE_CONFIRM;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			MODE_CONFIRM: begin
				wr_entry = 1'b1;
				if (last_key) begin
					count_d   = '0;
					mode_d    = MODE_IDLE;
					res.valid = 1'b1;
					if (!match_new_now) begin
						res.outcome = OUT_MISMATCH;
					end else begin
						commit      = 1'b1;
						res.outcome = OUT_UPDATED;
					end
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			default: begin
				count_d = '0;
				if (key == KEY_PLUS) mode_d = MODE_ENTRY;
				else if (key == KEY_MINUS) mode_d = MODE_MENU;
				else mode_d = MODE_IDLE;
			end
		endcase
		if (!fire) res = '0;
	end

	// control state and stored password
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			count_q  <= '0;
			stored_q <= reset_password();
		end else if (fire) begin
			mode_q  <= mode_d;
			count_q <= count_d;
			if (commit) stored_q <= new_q;
		end
	end

	// key buffers, no reset
	always_ff @(posedge clk) begin
		if (fire && wr_entry) entry_q[idx] <= key;
		if (fire && wr_new) new_q[idx] <= key;
	end

	// count never passes the password length
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(PASSWORD_LENGTH))
		else $error("entry count beyond password length");

	// change phases always have room for the current key
	a_change_room: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_OLD || mode_q == MODE_NEW || mode_q == MODE_CONFIRM)
		|-> count_q < CNT_W'(PASSWORD_LENGTH))
		else $error("change phase with full buffer");

	// a result is only produced by a processed key
	a_res_fire: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> fire)
		else $error("result without processed key");

	// an update stores the new password
	a_update_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.outcome == OUT_UPDATED) |=> stored_q == $past(new_q))
		else $error("update did not store new password");

	// every result returns the lock to idle
	a_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |=> (mode_q == MODE_IDLE && count_q == '0))
		else $error("result without return to idle");

endmodule

[sv/keypad_password_lock.sv]
// keypad_password_lock: top level with input register, lock core and result register
// a key item is accepted into the input register, then the core step loads any result into the result register
// throughput: one key item per cycle while the result side accepts
// a result waiting in the result register holds the core step, then the input register fills
// reset: arst_n clears mode and count, restores password "12345", empties both registers
// depends on kpl_pkg and kpl_core
module keypad_password_lock (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] key_code
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // [2:0] outcome, [7:3] zero
);
	import kpl_pkg::*;

	logic             valid_s1;
	logic [KEY_W-1:0] key_s1;
	logic             fire;
	kpl_result_t      res;
	logic             out_valid_q;
	logic [OUTCOME_W-1:0] outcome_q;

	// core step when the result register is free or being emptied
	assign fire     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) key_s1 <= s_tdata[KEY_W-1:0];
	end

	kpl_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.key    (key_s1),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) outcome_q <= res.outcome;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(8 - OUTCOME_W){1'b0}}, outcome_q};

endmodule

[verif/tb_keypad_password_lock.sv]
`timescale 1ns / 1ps
// tb_keypad_password_lock: self-checking testbench for the keypad password lock
// predicts each outcome item from the key items and compares it; depends on kpl_pkg and the rtl
module tb_keypad_password_lock;
	import kpl_pkg::*;

	localparam int KEY_TARGET  = 950;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 4;

	// lock behavior predictor with its queue of outcomes still to arrive
	class lock_predictor;
		logic [2:0]           mode;
		int unsigned          fill;
		pw_t                  stored;
		pw_t                  typed;
		pw_t                  fresh;
		logic [OUTCOME_W-1:0] outcomes_due[$];
		int                   errors;

		function new();
			mode   = MODE_IDLE;
			fill   = 0;
			typed  = '0;
			fresh  = '0;
			errors = 0;
			for (int i = 0; i < PASSWORD_LENGTH; i++) begin
				stored[i] = KEY_ONE + KEY_W'(i);
			end
		endfunction

		// step the lock on one accepted key item; returns 0 when the key had no effect
		function bit note_key(input logic [KEY_W-1:0] key);
			bit acted;
			acted = 1'b1;
			case (mode)
				MODE_ENTRY: begin
					if (key == KEY_STAR) begin
						if (fill > 0) fill--;
						else acted = 1'b0;
					end else if (key == KEY_HASH) begin
						outcomes_due.push_back((fill == PASSWORD_LENGTH && typed == stored) ?
							OUT_VALID : OUT_WRONG);
						mode = MODE_IDLE;
						fill = 0;
					end else if (fill < PASSWORD_LENGTH) begin
						typed[fill] = key;
						fill++;
					end else begin
						acted = 1'b0;
					end
				end
				MODE_MENU: begin
					fill = 0;
					mode = (key == KEY_THREE) ? MODE_OLD : MODE_IDLE;
				end
				MODE_OLD: begin
					typed[fill] = key;
					fill++;
					if (fill == PASSWORD_LENGTH) begin
						fill = 0;
						if (typed != stored) begin
							mode = MODE_IDLE;
							outcomes_due.push_back(OUT_WRONG_OLD);
						end else begin
							mode = MODE_NEW;
						end
					end
				end
				MODE_NEW: begin
					fresh[fill] = key;
					fill++;
					if (fill == PASSWORD_LENGTH) begin
						fill = 0;
						mode = MODE_CONFIRM;
					end
				end
				MODE_CONFIRM: begin
					typed[fill] = key;
					fill++;
					if (fill == PASSWORD_LENGTH) begin
						fill = 0;
						mode = MODE_IDLE;
						if (typed != fresh) begin
							outcomes_due.push_back(OUT_MISMATCH);
						end else begin
							stored = fresh;
							outcomes_due.push_back(OUT_UPDATED);
						end
					end
				end
				default: begin
					acted = (key == KEY_PLUS) || (key == KEY_MINUS);
					fill  = 0;
					if (key == KEY_PLUS) mode = MODE_ENTRY;
					else if (key == KEY_MINUS) mode = MODE_MENU;
					else mode = MODE_IDLE;
				end
			endcase
			return acted;
		endfunction

		function void flag(input string what, input int want, input int got);
			errors++;
			if (errors <= 10) begin
				$display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
			end
		endfunction

		// compare one accepted outcome item with the oldest prediction
		function void check_outcome(input logic [7:0] data);
			logic [OUTCOME_W-1:0] want;
			if (outcomes_due.size() == 0) begin
				flag("outcome with none pending", -1, data);
			end else begin
				want = outcomes_due.pop_front();
				if (data[OUTCOME_W-1:0] !== want) flag("outcome", want, data[OUTCOME_W-1:0]);
				if (data[7:OUTCOME_W] !== '0) flag("tdata padding", 0, data[7:OUTCOME_W]);
			end
		endfunction

		function void leftover_check();
			if (outcomes_due.size() != 0) flag("outcomes never delivered", 0, outcomes_due.size());
		endfunction

		function int pending();
			return outcomes_due.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;   // [7:0] key_code
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;        // [2:0] outcome, [7:3] zero

	lock_predictor lock = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int keys_counted = 0;
	int quiet_cycles = 0;
	int hold_count = 0;
	int hold_served = 0;

	keypad_password_lock DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// outcome checking and quiet-cycle count
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (arst_n && m_tvalid && m_tready) lock.check_outcome(m_tdata);
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_count != hold_served) begin
				hold_served = hold_count;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// watchdog on cycles with no item accepted
	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("tb_keypad_password_lock: done, errors");
		$finish;
	end

	// offer one key item, optionally after a gap, and note it once accepted
	task automatic send_key(input logic [7:0] key);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= key;
		do @(posedge clk); while (!s_tready);
		if (lock.note_key(key)) keys_counted++;
	endtask

	// drop valid and wait for every pending outcome
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (lock.pending() != 0);
	endtask

	// mostly digits, some control keys and raw bytes
	function automatic logic [7:0] rand_key();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 8'h30 + 8'($urandom_range(0, 9));
			6: begin
				case ($urandom_range(0, 6))
					0: return KEY_STAR;
					1: return KEY_HASH;
					2: return KEY_PLUS;
					3: return KEY_MINUS;
					4: return KEY_THREE;
					5: return 8'h00;
					default: return 8'hFF;
				endcase
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] digit_key();
		return 8'h30 + 8'($urandom_range(0, 9));
	endfunction

	// password entry: usually the right password, sometimes a typo fixed by erase
	task automatic try_entry();
		pw_t pw;
		int  n;
		pw = lock.stored;
		send_key(KEY_PLUS);
		if ($urandom_range(0, 99) < 55) begin
			for (int i = 0; i < PASSWORD_LENGTH; i++) begin
				if ($urandom_range(0, 99) < 10) begin
					send_key(digit_key());
					send_key(KEY_STAR);
				end
				send_key(pw[i]);
			end
		end else begin
			n = $urandom_range(0, 7);
			for (int i = 0; i < n; i++) send_key(($urandom_range(0, 9) == 0) ? KEY_STAR : rand_key());
		end
		send_key(KEY_HASH);
	endtask

	// password change: old, then new and confirm if the old one is right, each five keys
	task automatic try_change();
		pw_t pw;
		pw_t old_pw;
		pw_t new_pw;
		int  slot;
		pw = lock.stored;
		old_pw = pw;
		if ($urandom_range(0, 99) < 20) begin
			slot = $urandom_range(0, PASSWORD_LENGTH - 1);
			old_pw[slot] = rand_key();
		end
		for (int i = 0; i < PASSWORD_LENGTH; i++) begin
			new_pw[i] = ($urandom_range(0, 99) < 75) ? digit_key() : rand_key();
		end
		send_key(KEY_MINUS);
		send_key(KEY_THREE);
		for (int i = 0; i < PASSWORD_LENGTH; i++) send_key(old_pw[i]);
		if (old_pw == pw) begin
			for (int i = 0; i < PASSWORD_LENGTH; i++) send_key(new_pw[i]);
			if ($urandom_range(0, 99) < 25) begin
				slot = $urandom_range(0, PASSWORD_LENGTH - 1);
				new_pw[slot] = rand_key();
			end
			for (int i = 0; i < PASSWORD_LENGTH; i++) send_key(new_pw[i]);
		end
	endtask

	task automatic random_sequence();
		int pick;
		logic [7:0] key;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			try_entry();
		end else if (pick < 70) begin
			try_change();
		end else if (pick < 80) begin
			send_key(KEY_MINUS);
			do key = rand_key(); while (key == KEY_THREE);
			send_key(key);
		end else begin
			repeat ($urandom_range(1, 4)) send_key(8'($urandom_range(0, 255)));
		end
	endtask

	// main flow
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full buffer drops extra keys, extreme byte values, erase then check
		send_key(KEY_PLUS);
		send_key(8'h00);
		send_key(8'hFF);
		send_key(8'h31);
		send_key(8'h32);
		send_key(8'h33);
		send_key(8'h34);
		send_key(KEY_STAR);
		send_key(KEY_HASH);
		// erase on empty buffer, then the reset password
		send_key(KEY_PLUS);
		send_key(KEY_STAR);
		for (int i = 0; i < PASSWORD_LENGTH; i++) send_key(KEY_ONE + 8'(i));
		send_key(KEY_HASH);
		// menu left by a key other than the change key
		send_key(KEY_MINUS);
		send_key(8'h37);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 47 : 0;
			recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 8 : 0;
			if (phase == 2) begin
				// long receiver hold-off while results keep coming
				hold_count <= hold_count + 1;
				repeat (12) begin
					send_key(KEY_PLUS);
					send_key(KEY_HASH);
				end
				wait_drained();
			end
			while (keys_counted < (phase + 1) * KEY_TARGET / 3) random_sequence();
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		lock.leftover_check();
		if (lock.errors == 0) begin
			$display("tb_keypad_password_lock: done, clean");
		end else begin
			$display("tb_keypad_password_lock: done, errors");
		end
		$finish;
	end

endmodule

[files.f]
sv/kpl_pkg.sv
sv/kpl_core.sv
sv/keypad_password_lock.sv
verif/tb_keypad_password_lock.sv
